>>> src/vpr_pkg.sv
// Shared types and constants for the VAR(p) recursion filter.
// No dependencies; imported by every module of the block.
package vpr_pkg;

    localparam int DATA_W  = 32;
    localparam int DIM_MAX = 8;
    localparam int LAG_MAX = 8;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ACT_COEF  = 2'd0,
        ACT_INIT  = 2'd1,
        ACT_INNOV = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_VECTOR_DIM = 2'd0,
        REG_LAG_ORDER  = 2'd1,
        REG_HAS_CONST  = 2'd2,
        REG_BURN_IN    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        TERM_MEM,
        TERM_CONST,
        TERM_INNOV
    } t_term;

    typedef struct packed {
        logic [3:0]  vector_dim;
        logic [3:0]  lag_order;
        logic        has_constant;
        logic [15:0] burn_in_count;
    } t_cfg;

    typedef struct packed {
        logic              clr;
        logic              vld;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mac_op;

endpackage

>>> src/vpr_cfg.sv
// APB-style configuration registers of the VAR(p) filter.
// Depends on vpr_pkg for the register index codes and the t_cfg struct.
module vpr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output vpr_pkg::t_cfg o_cfg
);
    import vpr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vector_dim    <= 4'd1;
            r_cfg.lag_order     <= 4'd1;
            r_cfg.has_constant  <= 1'b1;
            r_cfg.burn_in_count <= 16'd0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_VECTOR_DIM: r_cfg.vector_dim    <= pwdata[3:0];
                REG_LAG_ORDER:  r_cfg.lag_order     <= pwdata[3:0];
                REG_HAS_CONST:  r_cfg.has_constant  <= pwdata[0];
                REG_BURN_IN:    r_cfg.burn_in_count <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_VECTOR_DIM: prdata = {28'd0, r_cfg.vector_dim};
            REG_LAG_ORDER:  prdata = {28'd0, r_cfg.lag_order};
            REG_HAS_CONST:  prdata = {31'd0, r_cfg.has_constant};
            REG_BURN_IN:    prdata = {16'd0, r_cfg.burn_in_count};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

>>> src/vpr_mac.sv
// Shared multiply-accumulate unit with rounding and 32-bit saturation.
// Depends on vpr_pkg for t_mac_op and the saturation limits.
module vpr_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vpr_pkg::t_mac_op i_op,
    output logic            o_busy,
    output logic [31:0]     o_y
);
    import vpr_pkg::*;

    localparam int AW = 66 + $clog2(DIM_MAX * LAG_MAX + 2);

    logic signed [63:0]   r_prod;
    logic                 r_pv;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] sh;
    logic                 in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_op.vld && !i_op.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_op.a) * $signed(i_op.b);
        if (i_op.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + {{(AW-64){r_prod[63]}}, r_prod};
        end
    end

    // round half up, drop fraction, saturate
    assign rnd      = r_acc + (AW'(1) << (FRAC_BITS - 1));
    assign sh       = rnd >>> FRAC_BITS;
    assign in_range = (&sh[AW-1:31]) || !(|sh[AW-1:31]);
    assign o_y      = in_range ? sh[31:0] : (sh[AW-1] ? SAT_MIN : SAT_MAX);
    assign o_busy   = r_pv;

endmodule

>>> src/vpr_ctrl.sv
// Sequencer of the VAR(p) filter: coefficient and lag memories, pending
// vector, burn-in count, lag-line shift sweep and output register.
// Depends on vpr_pkg; drives the shared unit in vpr_mac.
module vpr_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vpr_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_action,
    input  logic [6:0]       i_row_index,
    input  logic [2:0]       i_component,
    input  logic [31:0]      i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_sample_value,
    output logic [2:0]       o_sample_component,
    output logic             o_vector_last,
    output vpr_pkg::t_mac_op o_mac_op,
    input  logic             i_mac_busy,
    input  logic [31:0]      i_mac_y
);
    import vpr_pkg::*;

    localparam int COEF_ROWS = DIM_MAX * LAG_MAX + 1;
    localparam int COEF_N    = COEF_ROWS * DIM_MAX;
    localparam int LAG_N     = LAG_MAX * DIM_MAX;
    localparam int CA_W      = $clog2(COEF_N);
    localparam int LA_W      = (LAG_N > 1) ? $clog2(LAG_N) : 1;
    localparam int LW        = $clog2(LAG_MAX + 1);
    localparam int CW        = $clog2(DIM_MAX + 1);
    localparam int PW        = $clog2(DIM_MAX);
    localparam int KW        = $clog2(DIM_MAX * LAG_MAX + 1);
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_CONST,
        S_INNOV,
        S_DRAIN,
        S_FIN,
        S_SHIFT
    } t_state;

    t_state r_state;

    logic [31:0] r_coef_mem [COEF_N];
    logic [31:0] r_lag_mem  [LAG_N];
    logic [31:0] r_coef_q;
    logic [31:0] r_lag_q;
    logic [31:0] r_pend [DIM_MAX];
    logic [31:0] r_pend_q;

    logic [LW-1:0]   r_l;
    logic [CW-1:0]   r_c;
    logic [KW-1:0]   r_k;
    logic [2:0]      r_comp;
    logic [31:0]     r_val;
    logic [15:0]     r_burn;
    logic            r_iv;
    t_term           r_ikind;
    logic            r_sw_v;
    logic            r_sw_pend;
    logic [LA_W-1:0] r_sw_addr;

    logic            r_out_vld;
    logic [31:0]     r_out_val;
    logic [2:0]      r_out_comp;
    logic            r_out_last;

    logic [CW-1:0]   m_eff;
    logic [LW-1:0]   p_eff;
    logic            accept;
    t_action         act;
    logic            coef_we;
    logic [CA_W-1:0] coef_waddr;
    logic [CA_W-1:0] coef_raddr;
    logic            init_we;
    logic [LA_W-1:0] init_waddr;
    logic [LA_W-1:0] lag_raddr;
    logic            innov_ok;
    logic            emit;
    logic            last;
    logic            space;
    logic            term_last;

    always_comb begin
        if (i_cfg.vector_dim == 4'd0) begin
            m_eff = CW'(1);
        end else if (32'(i_cfg.vector_dim) > DIM_MAX) begin
            m_eff = CW'(DIM_MAX);
        end else begin
            m_eff = CW'(i_cfg.vector_dim);
        end
        if (i_cfg.lag_order == 4'd0) begin
            p_eff = LW'(1);
        end else if (32'(i_cfg.lag_order) > LAG_MAX) begin
            p_eff = LW'(LAG_MAX);
        end else begin
            p_eff = LW'(i_cfg.lag_order);
        end
    end

    assign o_stall  = (r_state != S_IDLE) || r_sw_v;
    assign accept   = i_valid && !o_stall;
    assign act      = t_action'(i_action);

    assign coef_we    = accept && (act == ACT_COEF) && (32'(i_row_index) < COEF_ROWS)
                        && (32'(i_component) < DIM_MAX);
    assign coef_waddr = CA_W'(32'(i_row_index) * DIM_MAX + 32'(i_component));
    assign coef_raddr = CA_W'(32'(r_k) * DIM_MAX + 32'(r_comp));

    assign init_we    = accept && (act == ACT_INIT) && (32'(i_row_index) < 32'(p_eff))
                        && (32'(i_component) < DIM_MAX);
    assign init_waddr = LA_W'((32'(p_eff) - 32'd1 - 32'(i_row_index)) * DIM_MAX
                              + 32'(i_component));
    assign lag_raddr  = (r_state == S_SHIFT)
                        ? LA_W'((32'(r_l) - 32'd1) * DIM_MAX + 32'(r_c))
                        : LA_W'(32'(r_l) * DIM_MAX + 32'(r_c));

    assign innov_ok  = accept && (act == ACT_INNOV) && (32'(i_component) < 32'(m_eff));
    assign emit      = r_burn >= i_cfg.burn_in_count;
    assign last      = 32'(r_comp) == 32'(m_eff) - 32'd1;
    assign space     = !r_out_vld || !i_stall;
    assign term_last = (r_l == p_eff - LW'(1)) && (r_c == m_eff - CW'(1));

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= i_value;
        end
        r_coef_q <= r_coef_mem[coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_sw_v) begin
            r_lag_mem[r_sw_addr] <= r_sw_pend ? r_pend_q : r_lag_q;
        end else if (init_we) begin
            r_lag_mem[init_waddr] <= i_value;
        end
        r_lag_q <= r_lag_mem[lag_raddr];
    end

    assign o_mac_op.clr = innov_ok;
    assign o_mac_op.vld = r_iv;
    assign o_mac_op.a   = (r_ikind == TERM_INNOV) ? r_val : r_coef_q;
    assign o_mac_op.b   = (r_ikind == TERM_MEM) ? r_lag_q : ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iv      <= 1'b0;
            r_sw_v    <= 1'b0;
            r_out_vld <= 1'b0;
            r_burn    <= 16'd0;
            for (int i = 0; i < DIM_MAX; i++) begin
                r_pend[i] <= 32'd0;
            end
        end else begin
            r_iv   <= 1'b0;
            r_sw_v <= 1'b0;
            if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (innov_ok) begin
                        r_l     <= '0;
                        r_c     <= '0;
                        r_k     <= '0;
                        r_comp  <= i_component;
                        r_val   <= i_value;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_iv    <= 1'b1;
                    r_ikind <= TERM_MEM;
                    r_k     <= r_k + KW'(1);
                    if (r_c == m_eff - CW'(1)) begin
                        r_c <= '0;
                        r_l <= r_l + LW'(1);
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                    if (term_last) begin
                        r_state <= i_cfg.has_constant ? S_CONST : S_INNOV;
                    end
                end
                S_CONST: begin
                    r_iv    <= 1'b1;
                    r_ikind <= TERM_CONST;
                    r_state <= S_INNOV;
                end
                S_INNOV: begin
                    r_iv    <= 1'b1;
                    r_ikind <= TERM_INNOV;
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r_iv && !i_mac_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!emit || space) begin
                        r_pend[r_comp] <= i_mac_y;
                        if (emit) begin
                            r_out_vld  <= 1'b1;
                            r_out_val  <= i_mac_y;
                            r_out_comp <= r_comp;
                            r_out_last <= last;
                        end
                        if (last) begin
                            if (!emit) begin
                                r_burn <= r_burn + 16'd1;
                            end
                            r_l     <= p_eff - LW'(1);
                            r_c     <= '0;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT: begin
                    // oldest lag first read-then-write, lag 0 takes the pending vector
                    r_sw_v    <= 1'b1;
                    r_sw_addr <= LA_W'(32'(r_l) * DIM_MAX + 32'(r_c));
                    r_sw_pend <= (r_l == '0);
                    r_pend_q  <= r_pend[r_c[PW-1:0]];
                    if (r_c == m_eff - CW'(1)) begin
                        r_c <= '0;
                        if (r_l == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_l <= r_l - LW'(1);
                        end
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_out_vld;
    assign o_sample_value     = r_out_val;
    assign o_sample_component = r_out_comp;
    assign o_vector_last      = r_out_last;

endmodule

>>> src/var_p_recursion_filter_top.sv
// Top level of the VAR(p) recursion filter: registers, sequencer, MAC unit.
// Depends on vpr_pkg, vpr_cfg, vpr_ctrl and vpr_mac.
//
//  channel   signals                                   accepted when
//  input     i_valid o_stall i_action i_row_index       i_valid & !o_stall
//            i_component i_value
//  output    o_valid i_stall o_sample_value             o_valid & !i_stall
//            o_sample_component o_vector_last
//  config    psel penable pwrite paddr pwdata prdata    psel & penable & pwrite
//            pready
//
// An innovation streams its terms through the single multiply-accumulate, one term a
// cycle: m*p lag terms, the constant row when enabled, then the innovation; the last
// component adds a lag-line shift through the lag memory port.
// A result waiting in the output register blocks only the next result.
// Reset is synchronous, active low; it clears control and burn-in, sets registers to defaults.
module var_p_recursion_filter_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [6:0]  i_row_index,
    input  logic [2:0]  i_component,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_value,
    output logic [2:0]  o_sample_component,
    output logic        o_vector_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vpr_pkg::*;

    t_cfg        cfg;
    t_mac_op     mac_op;
    logic        mac_busy;
    logic [31:0] mac_y;

    vpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vpr_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_busy  (mac_busy),
        .o_y     (mac_y)
    );

    vpr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_row_index        (i_row_index),
        .i_component        (i_component),
        .i_value            (i_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_sample_value     (o_sample_value),
        .o_sample_component (o_sample_component),
        .o_vector_last      (o_vector_last),
        .o_mac_op           (mac_op),
        .i_mac_busy         (mac_busy),
        .i_mac_y            (mac_y)
    );

endmodule

>>> dv/tb_var_p_recursion_filter_top.sv
// Self-checking testbench for var_p_recursion_filter_top: loads, innovations, burn-in.
// A scoreboard class predicts each sample in Q16.16; tasks drive the item and APB ports.
// Depends on vpr_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_var_p_recursion_filter_top;
    import vpr_pkg::*;

    localparam int FRAC          = 16;
    localparam int COEF_ROWS     = DIM_MAX * LAG_MAX + 1;
    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 50_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int IDLE_PCT      = 19;
    localparam int NOISE_PCT     = 12;
    localparam int RANDOM_ITEMS  = 750;
    localparam int RELOAD_ROWS   = 17;
    localparam int LAG_SPAN      = 65536;
    localparam int MAX_PRINTED   = 40;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [127:0] SUM_HI    = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SUM_LO    = -128'sh8000_0000;
    localparam logic signed [127:0] ROUND_ADD = 128'sd32768;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  comp;
        logic        last;
    } t_sample_exp;

    class var_sample_scoreboard;
        logic [31:0] coef_mem [COEF_ROWS*DIM_MAX];
        logic [31:0] lag_mem [LAG_MAX*DIM_MAX];
        logic [31:0] pend [DIM_MAX];
        logic [15:0] burn_cnt;
        logic [3:0]  dim_reg;
        logic [3:0]  lag_reg;
        logic        const_en;
        logic [15:0] burn_lim;
        t_sample_exp expected_samples[$];
        int errors;
        int checked;
        int saturated;
        int accepted;

        function new();
            foreach (coef_mem[i]) coef_mem[i] = '0;
            foreach (lag_mem[i]) lag_mem[i] = '0;
            foreach (pend[i]) pend[i] = '0;
            burn_cnt  = '0;
            dim_reg   = 4'd1;
            lag_reg   = 4'd1;
            const_en  = 1'b1;
            burn_lim  = '0;
            errors    = 0;
            checked   = 0;
            saturated = 0;
            accepted  = 0;
        endfunction

        function int eff_dim();
            if (dim_reg < 1) return 1;
            if (dim_reg > DIM_MAX) return DIM_MAX;
            return int'(dim_reg);
        endfunction

        function int eff_lag();
            if (lag_reg < 1) return 1;
            if (lag_reg > LAG_MAX) return LAG_MAX;
            return int'(lag_reg);
        endfunction

        function int pending_count();
            return expected_samples.size();
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] data);
            case (idx)
                REG_VECTOR_DIM: dim_reg = data[3:0];
                REG_LAG_ORDER:  lag_reg = data[3:0];
                REG_HAS_CONST:  const_en = data[0];
                REG_BURN_IN:    burn_lim = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] predict_sample(int comp, logic [31:0] innov);
            logic signed [127:0] acc;
            logic signed [127:0] term;
            longint prod;
            int m;
            int p;
            m = eff_dim();
            p = eff_lag();
            acc = '0;
            for (int l = 0; l < p; l++) begin
                for (int c = 0; c < m; c++) begin
                    prod = longint'($signed(lag_mem[l*DIM_MAX + c]))
                         * longint'($signed(coef_mem[(l*m + c)*DIM_MAX + comp]));
                    term = 128'(prod);
                    acc = acc + term;
                end
            end
            if (const_en) begin
                term = 128'($signed(coef_mem[(m*p)*DIM_MAX + comp]));
                acc = acc + (term <<< FRAC);
            end
            term = 128'($signed(innov));
            acc = acc + (term <<< FRAC) + ROUND_ADD;
            acc = acc >>> FRAC;
            if (acc > SUM_HI) begin
                saturated++;
                return SAT_MAX;
            end
            if (acc < SUM_LO) begin
                saturated++;
                return SAT_MIN;
            end
            return acc[31:0];
        endfunction

        function void note_input(logic [1:0] act, logic [6:0] row, logic [2:0] comp,
                                 logic [31:0] val);
            int m;
            int p;
            logic [31:0] y;
            bit last;
            bit emit;
            t_sample_exp e;
            accepted++;
            m = eff_dim();
            p = eff_lag();
            case (act)
                ACT_COEF: begin
                    if (int'(row) < COEF_ROWS && int'(comp) < DIM_MAX)
                        coef_mem[int'(row)*DIM_MAX + int'(comp)] = val;
                end
                ACT_INIT: begin
                    if (int'(row) < p && int'(comp) < DIM_MAX)
                        lag_mem[(p - 1 - int'(row))*DIM_MAX + int'(comp)] = val;
                end
                ACT_INNOV: begin
                    if (int'(comp) < m) begin
                        y = predict_sample(int'(comp), val);
                        pend[comp] = y;
                        last = (int'(comp) == m - 1);
                        emit = (burn_cnt >= burn_lim);
                        if (last) begin
                            for (int l = p - 1; l >= 1; l--)
                                for (int c = 0; c < m; c++)
                                    lag_mem[l*DIM_MAX + c] = lag_mem[(l-1)*DIM_MAX + c];
                            for (int c = 0; c < m; c++)
                                lag_mem[c] = pend[c];
                            if (burn_cnt < burn_lim)
                                burn_cnt = burn_cnt + 16'd1;
                        end
                        if (emit) begin
                            e.value = y;
                            e.comp  = comp;
                            e.last  = last;
                            expected_samples.push_back(e);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR %0d: %s", errors, what);
        endtask

        task check_result(logic [31:0] v, logic [2:0] c, logic l);
            t_sample_exp e;
            if (expected_samples.size() == 0) begin
                report($sformatf("unexpected sample %h component %0d", v, c));
            end else begin
                e = expected_samples.pop_front();
                checked++;
                if (v !== e.value)
                    report($sformatf("sample_value got %h want %h (component %0d)",
                                     v, e.value, e.comp));
                if (c !== e.comp)
                    report($sformatf("sample_component got %0d want %0d", c, e.comp));
                if (l !== e.last)
                    report($sformatf("vector_last got %b want %b (component %0d)",
                                     l, e.last, e.comp));
            end
        endtask

        task check_leftovers();
            t_sample_exp e;
            while (expected_samples.size() != 0) begin
                e = expected_samples.pop_front();
                report($sformatf("sample %h component %0d never arrived", e.value, e.comp));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [6:0]  i_row_index = '0;
    logic [2:0]  i_component = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_sample_value;
    logic [2:0]  o_sample_component;
    logic        o_vector_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    var_sample_scoreboard sb;
    int cycle_count = 0;
    int in_idle_pct = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int settings_count = 0;

    var_p_recursion_filter_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_row_index        (i_row_index),
        .i_component        (i_component),
        .i_value            (i_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_sample_value     (o_sample_value),
        .o_sample_component (o_sample_component),
        .o_vector_last      (o_vector_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_sample_value, o_sample_component, o_vector_last);
    end

    function automatic logic [31:0] rand_span(int span);
        return $urandom_range(2*span) - span;
    endfunction

    function automatic logic [3:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 4'($urandom_range(1, 4));
        if (r < 93) return 4'($urandom_range(5, 8));
        if ($urandom_range(1) == 0) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [3:0] raw_m, logic [3:0] raw_p, logic hc,
                              logic [15:0] burn);
        apb_write(REG_VECTOR_DIM, {28'd0, raw_m});
        apb_write(REG_LAG_ORDER, {28'd0, raw_p});
        apb_write(REG_HAS_CONST, {31'd0, hc});
        apb_write(REG_BURN_IN, {16'd0, burn});
        settings_count++;
    endtask

    task automatic send_item(logic [1:0] act, logic [6:0] row, logic [2:0] comp,
                             logic [31:0] val);
        while ($urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_row_index <= row;
        i_component <= comp;
        i_value     <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(act, row, comp, val);
    endtask

    task automatic drain_and_wait();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending_count() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_noise();
        int r;
        logic [31:0] v;
        r = $urandom_range(99);
        v = ($urandom_range(99) < 20) ? $urandom : rand_span(2000);
        if (r < 25)
            send_item(ACT_COEF, 7'($urandom_range(127)), 3'($urandom_range(7)), v);
        else if (r < 45)
            send_item(ACT_INIT, ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                         : 7'($urandom_range(15)),
                      3'($urandom_range(7)), rand_span(LAG_SPAN));
        else if (r < 70)
            send_item(ACT_INNOV, 7'($urandom_range(127)), 3'($urandom_range(7)),
                      rand_span(LAG_SPAN));
        else if (r < 85)
            send_item(ACT_INNOV, 7'($urandom_range(127)), 3'($urandom_range(7)),
                      $urandom);
        else
            send_item(ACT_UNUSED, 7'($urandom_range(127)), 3'($urandom_range(7)),
                      $urandom);
    endtask

    task automatic run_phase(logic [3:0] raw_m, logic [3:0] raw_p, logic hc,
                             logic [15:0] burn, int n_vec);
        int m;
        int p;
        int rows;
        int bound;
        int nxt;
        logic [31:0] v;
        set_config(raw_m, raw_p, hc, burn);
        m = sb.eff_dim();
        p = sb.eff_lag();
        rows = m*p + int'(hc);
        if (rows <= RELOAD_ROWS) begin
            bound = 32768 / rows;
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < m; c++)
                    send_item(ACT_COEF, 7'(r), 3'(c), rand_span(bound));
        end
        for (int r = 0; r < p; r++)
            for (int c = 0; c < m; c++)
                send_item(ACT_INIT, 7'(r), 3'(c), rand_span(LAG_SPAN));
        nxt = 0;
        for (int k = 0; k < n_vec*m; k++) begin
            if ($urandom_range(99) < NOISE_PCT) begin
                send_noise();
            end else begin
                v = ($urandom_range(99) < 6) ? $urandom : rand_span(LAG_SPAN);
                send_item(ACT_INNOV, 7'($urandom_range(127)), 3'(nxt), v);
                nxt = (nxt + 1) % m;
            end
        end
        drain_and_wait();
    endtask

    initial begin
        int base;
        int phase;
        int r;
        logic [15:0] burn;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every store entry first so no innovation reads an unwritten one
        set_config(4'd8, 4'd8, 1'b1, 16'd0);
        for (int row = 0; row < COEF_ROWS; row++)
            for (int c = 0; c < DIM_MAX; c++)
                send_item(ACT_COEF, 7'(row), 3'(c), rand_span(400));
        for (int row = 0; row < LAG_MAX; row++)
            for (int c = 0; c < DIM_MAX; c++)
                send_item(ACT_INIT, 7'(row), 3'(c), rand_span(LAG_SPAN));
        drain_and_wait();

        set_config(4'd2, 4'd2, 1'b1, 16'd0);
        send_item(ACT_COEF, 7'd64, 3'd7, SAT_MAX);
        send_item(ACT_COEF, 7'd127, 3'd3, SAT_MIN);
        send_item(ACT_COEF, 7'd65, 3'd0, 32'h1234_5678);
        send_item(ACT_INIT, 7'd2, 3'd0, 32'h0001_0000);
        send_item(ACT_INIT, 7'd0, 3'd1, SAT_MIN);
        send_item(ACT_INIT, 7'd1, 3'd0, SAT_MAX);
        send_item(ACT_COEF, 7'd4, 3'd0, SAT_MAX);
        send_item(ACT_COEF, 7'd4, 3'd1, SAT_MIN);
        send_item(ACT_INNOV, 7'd0, 3'd0, SAT_MAX);
        send_item(ACT_INNOV, 7'd127, 3'd1, SAT_MIN);
        send_item(ACT_INNOV, 7'd0, 3'd5, 32'h0);
        send_item(ACT_UNUSED, 7'd127, 3'd7, 32'hFFFF_FFFF);
        send_item(ACT_INNOV, 7'd0, 3'd1, 32'h0);
        send_item(ACT_INNOV, 7'd0, 3'd0, 32'h0);
        send_item(ACT_COEF, 7'd4, 3'd0, 32'h0000_0100);
        send_item(ACT_COEF, 7'd4, 3'd1, 32'hFFFF_FF00);
        send_item(ACT_COEF, 7'd64, 3'd7, 32'h0000_0100);
        drain_and_wait();

        // rounding at exactly half an lsb, both signs, behind two held vectors
        set_config(4'd1, 4'd1, 1'b0, 16'd2);
        send_item(ACT_COEF, 7'd0, 3'd0, 32'h0000_8000);
        send_item(ACT_INIT, 7'd0, 3'd0, 32'hFFFF_FFFF);
        send_item(ACT_INNOV, 7'd0, 3'd0, 32'h0);
        send_item(ACT_INNOV, 7'd0, 3'd0, 32'h0);
        send_item(ACT_INIT, 7'd0, 3'd0, 32'h0000_0001);
        send_item(ACT_INNOV, 7'd0, 3'd0, 32'h0);
        send_item(ACT_INIT, 7'd0, 3'd0, 32'hFFFF_FFFF);
        send_item(ACT_INNOV, 7'd0, 3'd0, 32'h0);
        drain_and_wait();

        base = sb.accepted;
        phase = 0;
        while (sb.accepted - base < RANDOM_ITEMS) begin
            case (phase)
                0: run_phase(4'd8, 4'd8, 1'b1, 16'd0, 3);
                1: run_phase(4'd1, 4'd1, 1'b0, 16'd0, 30);
                2: run_phase(4'd0, 4'd15, 1'b1, 16'd0, 8);
                3: begin
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                    run_phase(4'd15, 4'd0, 1'b0, 16'd0, 30);
                    in_idle_pct = IDLE_PCT;
                    out_idle_pct = IDLE_PCT;
                end
                4: run_phase(4'd2, 4'd2, 1'b1, 16'hFFFF, 6);
                5: run_phase(4'd3, 4'd2, 1'b1, sb.burn_cnt + 16'd3, 10);
                default: begin
                    r = $urandom_range(99);
                    if (r < 70) burn = 16'd0;
                    else if (r < 92) burn = sb.burn_cnt + 16'($urandom_range(1, 3));
                    else burn = 16'($urandom_range(65535));
                    run_phase(pick_size(), pick_size(), 1'($urandom_range(1)), burn,
                              int'($urandom_range(4, 16)));
                end
            endcase
            phase++;
        end

        drain_and_wait();
        sb.check_leftovers();
        $display("Summary: %0d items over %0d register settings, %0d samples checked, %0d saturated",
                 sb.accepted, settings_count, sb.checked, sb.saturated);
        $display("Summary: sizes 1 to 8 with clamped codes, constant row on and off, burn-in to 65535");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
